// File: rtl/spcp_pkg.sv
// Shared types and constants for the serial PWM command parser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package spcp_pkg;

    localparam int unsigned MAX_LEN  = 30;
    localparam int unsigned DUTY_MAX = 1023;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DUTY_W   = 10;
    localparam int unsigned ACC_W    = 11;   // holds DUTY_MAX + 1 on saturation
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned FIELD_W  = 3;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned MASK_W   = 4;
    localparam int unsigned TDATA_W  = 48;

    localparam logic [BYTE_W-1:0] TERM_RESET = 8'd36;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'd9;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'd43;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'd44;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'd45;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'd48;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'd57;

    localparam logic [BYTE_W-1:0] LETTER_A = 8'd97;
    localparam logic [BYTE_W-1:0] LETTER_W = 8'd119;
    localparam logic [BYTE_W-1:0] LETTER_B = 8'd98;
    localparam logic [BYTE_W-1:0] LETTER_G = 8'd103;
    localparam logic [BYTE_W-1:0] LETTER_R = 8'd114;
    localparam logic [BYTE_W-1:0] LETTER_V = 8'd118;
    localparam logic [BYTE_W-1:0] LETTER_F = 8'd102;

    localparam logic [KIND_W-1:0] KIND_ALL     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WHITE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BLUE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GREEN   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RED     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_VERSION = 3'd5;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd6;

    localparam logic [MASK_W-1:0] MASK_NONE  = 4'd0;
    localparam logic [MASK_W-1:0] MASK_RED   = 4'd1;
    localparam logic [MASK_W-1:0] MASK_GREEN = 4'd2;
    localparam logic [MASK_W-1:0] MASK_BLUE  = 4'd4;
    localparam logic [MASK_W-1:0] MASK_WHITE = 4'd8;
    localparam logic [MASK_W-1:0] MASK_ALL   = 4'd15;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } num_phase_t;

    // Classified byte passed from the front end to the parser.
    typedef struct packed {
        logic              is_term;
        logic [BYTE_W-1:0] data;
    } tok_t;

    typedef struct packed {
        num_phase_t       phase;
        logic [ACC_W-1:0] acc;
        logic             neg;
    } num_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MASK_W-1:0] mask;
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
        logic [DUTY_W-1:0] white;
    } result_t;

endpackage

// File: rtl/serial_pwm_command_parser_core.sv
// Top level of the serial PWM command parser: front end, queue and parser.
// Depends on spcp_pkg, spcp_front, spcp_fifo and spcp_back.
`timescale 1ns / 1ps
// One received byte is taken per cycle on the s_ channel while the queue is
// not full. A terminator byte (set by cfg_wr_data, '$' after reset) closes a
// command. With the queue empty and the output register free, the terminator
// passes through a queue entry and then the output register before m_tvalid
// rises. The rate of one byte per cycle is set by the parser, which updates
// its small set of registers once per byte and holds while a result waits on
// m_tready; the two-entry queue between the classifier and the parser buffers
// bytes while it holds, and s_tready falls once the queue is full.
// m_tuser carries the command kind, m_tdata the write mask and four duties.
module serial_pwm_command_parser_core
    import spcp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [BYTE_W-1:0]  cfg_wr_data,  // terminator_byte
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,      // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    // [3:0] write_mask, [13:4] duty_red, [23:14] duty_green,
    // [33:24] duty_blue, [43:34] duty_white, [47:44] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]  m_tuser       // [2:0] cmd_kind
);

    logic    push;
    tok_t    push_tok;
    logic    full;
    logic    empty;
    logic    pop;
    tok_t    head_tok;
    result_t res;

    assign s_tready = !full;

    spcp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_xfer     (s_tvalid && s_tready),
        .in_byte     (s_tdata),
        .push        (push),
        .push_tok    (push_tok)
    );

    spcp_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_tok (push_tok),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_tok (head_tok)
    );

    spcp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (!empty),
        .tok       (head_tok),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {4'b0000, res.white, res.blue, res.green, res.red, res.mask};

endmodule

// File: rtl/spcp_front.sv
// Front end: holds the terminator register and classifies received bytes.
// Depends on spcp_pkg.
`timescale 1ns / 1ps
module spcp_front
    import spcp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              in_xfer,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              push,
    output tok_t              push_tok
);

    logic [BYTE_W-1:0] term_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg <= TERM_RESET;
        end else if (cfg_wr_en) begin
            term_reg <= cfg_wr_data;
        end
    end

    logic is_term;
    logic is_crlf;

    assign is_term = (in_byte == term_reg);
    assign is_crlf = (in_byte == CH_LF) || (in_byte == CH_CR);

    // Drop CR and LF here unless they are the terminator.
    assign push          = in_xfer && (is_term || !is_crlf);
    assign push_tok.is_term = is_term;
    assign push_tok.data    = in_byte;

endmodule

// File: rtl/spcp_fifo.sv
// Two-entry queue of classified bytes between the front end and the parser.
// Depends on spcp_pkg.
`timescale 1ns / 1ps
module spcp_fifo
    import spcp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  tok_t push_tok,
    output logic full,
    input  logic pop,
    output logic empty,
    output tok_t head_tok
);

    tok_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_tok = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/spcp_back.sv
// Back end: command parser state, number scanner and the result register.
// Depends on spcp_pkg.
`timescale 1ns / 1ps
module spcp_back
    import spcp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    tok_valid,
    input  tok_t    tok,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    function automatic logic is_space(input logic [BYTE_W-1:0] ch);
        return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    endfunction

    function automatic num_t feed(input num_t cur, input logic [BYTE_W-1:0] ch);
        num_t             n;
        logic             digit;
        logic [3:0]       d;
        logic [ACC_W+3:0] prod;
        n     = cur;
        digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d     = digit ? 4'(ch - CH_ZERO) : 4'd0;
        prod  = {cur.acc, 3'b000} + {2'b00, cur.acc, 1'b0} + (ACC_W+4)'(d);
        case (cur.phase)
            PH_LEAD: begin
                if (is_space(ch)) begin
                    n.phase = PH_LEAD;
                end else if (ch == CH_PLUS) begin
                    n.phase = PH_SIGN;
                end else if (ch == CH_MINUS) begin
                    n.neg   = 1'b1;
                    n.phase = PH_SIGN;
                end else if (digit) begin
                    n.acc   = ACC_W'(d);
                    n.phase = PH_DIGITS;
                end else begin
                    n.phase = PH_DONE;
                end
            end
            PH_SIGN: begin
                if (digit) begin
                    n.acc   = ACC_W'(d);
                    n.phase = PH_DIGITS;
                end else begin
                    n.phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                if (digit) begin
                    if (prod > (ACC_W+4)'(DUTY_MAX)) begin
                        n.acc = ACC_W'(DUTY_MAX + 1);
                    end else begin
                        n.acc = prod[ACC_W-1:0];
                    end
                end else begin
                    n.phase = PH_DONE;
                end
            end
            default: begin
                n = cur;
            end
        endcase
        return n;
    endfunction

    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [BYTE_W-1:0]  letter_reg, letter_next;
    logic [FIELD_W-1:0] field_reg,  field_next;
    logic               started_reg, started_next;
    num_t               num_reg,    num_next;
    logic [DUTY_W-1:0]  pend_reg [4];
    logic [DUTY_W-1:0]  pend_next [4];

    logic    out_valid_reg;
    result_t out_res_reg;
    logic    give;
    result_t res;

    logic [DUTY_W-1:0] all_val;
    logic [DUTY_W-1:0] one_val;
    logic              count_ok;
    logic              closing;

    assign pop       = tok_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign all_val = (num_reg.neg || (num_reg.acc > ACC_W'(DUTY_MAX)))
                   ? '0 : num_reg.acc[DUTY_W-1:0];
    assign one_val = num_reg.neg ? '0
                   : ((num_reg.acc > ACC_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                       : num_reg.acc[DUTY_W-1:0]);
    assign count_ok = (count_reg >= COUNT_W'(1)) && (count_reg < COUNT_W'(MAX_LEN));
    assign closing  = started_reg && (field_reg < FIELD_W'(4));

    // Parser state update.
    always_comb begin
        count_next   = count_reg;
        letter_next  = letter_reg;
        field_next   = field_reg;
        started_next = started_reg;
        num_next     = num_reg;
        for (int i = 0; i < 4; i++) begin
            pend_next[i] = pend_reg[i];
        end
        if (tok.is_term || (count_reg >= COUNT_W'(MAX_LEN))) begin
            // End of command or overlong command: restart parsing.
            count_next   = '0;
            letter_next  = '0;
            field_next   = '0;
            started_next = 1'b0;
            num_next     = '{phase: PH_LEAD, acc: '0, neg: 1'b0};
            for (int i = 0; i < 4; i++) begin
                pend_next[i] = '0;
            end
        end else begin
            count_next = count_reg + COUNT_W'(1);
            if (count_reg == '0) begin
                letter_next = tok.data;
            end else if (letter_reg == LETTER_A) begin
                if (tok.data == CH_COMMA) begin
                    if (closing) begin
                        for (int i = 0; i < 4; i++) begin
                            if (field_reg == FIELD_W'(i)) begin
                                pend_next[i] = all_val;
                            end
                        end
                        field_next = field_reg + FIELD_W'(1);
                    end
                    started_next = 1'b0;
                    num_next     = '{phase: PH_LEAD, acc: '0, neg: 1'b0};
                end else begin
                    started_next = 1'b1;
                    num_next     = feed(num_reg, tok.data);
                end
            end else begin
                num_next = feed(num_reg, tok.data);
            end
        end
    end

    // Result of a terminator.
    always_comb begin
        give      = 1'b0;
        res       = '0;
        if (tok.is_term && count_ok) begin
            give = 1'b1;
            case (letter_reg)
                LETTER_A: begin
                    res.kind  = KIND_ALL;
                    res.mask  = MASK_ALL;
                    res.red   = (closing && field_reg == FIELD_W'(0)) ? all_val : pend_reg[0];
                    res.green = (closing && field_reg == FIELD_W'(1)) ? all_val : pend_reg[1];
                    res.blue  = (closing && field_reg == FIELD_W'(2)) ? all_val : pend_reg[2];
                    res.white = (closing && field_reg == FIELD_W'(3)) ? all_val : pend_reg[3];
                end
                LETTER_W: begin
                    res.kind  = KIND_WHITE;
                    res.mask  = MASK_WHITE;
                    res.white = one_val;
                end
                LETTER_B: begin
                    res.kind = KIND_BLUE;
                    res.mask = MASK_BLUE;
                    res.blue = one_val;
                end
                LETTER_G: begin
                    res.kind  = KIND_GREEN;
                    res.mask  = MASK_GREEN;
                    res.green = one_val;
                end
                LETTER_R: begin
                    res.kind = KIND_RED;
                    res.mask = MASK_RED;
                    res.red  = one_val;
                end
                LETTER_V: begin
                    res.kind = KIND_VERSION;
                    res.mask = MASK_NONE;
                end
                LETTER_F: begin
                    res.kind = KIND_FLUSH;
                    res.mask = MASK_NONE;
                end
                default: begin
                    give = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            letter_reg  <= '0;
            field_reg   <= '0;
            started_reg <= 1'b0;
            num_reg     <= '{phase: PH_LEAD, acc: '0, neg: 1'b0};
            for (int i = 0; i < 4; i++) begin
                pend_reg[i] <= '0;
            end
        end else if (pop) begin
            count_reg   <= count_next;
            letter_reg  <= letter_next;
            field_reg   <= field_next;
            started_reg <= started_next;
            num_reg     <= num_next;
            for (int i = 0; i < 4; i++) begin
                pend_reg[i] <= pend_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pop) begin
            out_valid_reg <= give;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && give) begin
            out_res_reg <= res;
        end
    end

endmodule
